### design/pzth_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pzth_pkg
// Shared types and constants for the power time-in-zone histogram.
// ----------------------------------------------------------------------------
package pzth_pkg;

    localparam int ZONES    = 7;
    localparam int EDGES    = ZONES - 1;
    localparam int ACC_W    = 32;
    localparam int TIME_W   = 25;
    localparam int POWER_W  = 12;
    localparam int FTP_W    = 11;
    localparam int STOP_W   = 8;
    localparam int ZONE_W   = 3;
    localparam int CFG_IDX_W = 2;

    // zone code for a step that is not counted
    localparam logic [ZONE_W-1:0] NO_ZONE = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FTP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP = 2'd1;

    localparam logic [STOP_W-1:0] STOP_RST = 8'd20;

    // power is scaled by 20, edges are ftp times these (0.55 .. 1.50 of FTP)
    localparam logic [4:0] POWER_SCALE = 5'd20;
    localparam logic [EDGES-1:0][4:0] EDGE_K = {5'd30, 5'd24, 5'd21, 5'd18, 5'd15, 5'd11};

    // accumulator update request
    typedef struct packed {
        logic              clear;
        logic              add;
        logic [ZONE_W-1:0] zone;
        logic [STOP_W-1:0] step;
    } t_acc_upd;

endpackage : pzth_pkg
`default_nettype wire

### design/power_zone_time_histogram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// power_zone_time_histogram
// Time-in-zone histogram of cycling power over seven FTP-relative zones.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one sample word: new-track
//   flag, signed time stamp in seconds (negative = missing) and power in watts.
//   Output channel (o_out_valid / i_out_ready) returns one result word per
//   sample: credited zone (7 = not counted), seven zone totals, overall total
//   and a table-valid flag.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes FTP (index
//   0) and the stop limit (index 1). Write only while the block is idle.
// Pipeline: a sample passes the input register, then the result register,
//   whose valid flag marks the result. Throughput: one sample per cycle
//   while results are taken; the state update of one sample lands in the
//   same edge that loads its result, so the next sample sees it.
// Stall: while the result is held the input register keeps one more sample,
//   then o_in_ready drops until the result is taken.
// Reset: synchronous, active low. FTP = 0, stop limit = 20 s, accumulators
//   cleared, no previous time stamp, both pipeline stages empty.
// ----------------------------------------------------------------------------
module power_zone_time_histogram import pzth_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FTP_W-1:0]     i_cfg_data,
    // samples
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_new_track,
    input  wire logic [TIME_W-1:0]    i_time_s,
    input  wire logic [POWER_W-1:0]   i_power_w,
    // results
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [ZONE_W-1:0]    o_zone_hit,
    output logic      [ACC_W-1:0]     o_zone1_s,
    output logic      [ACC_W-1:0]     o_zone2_s,
    output logic      [ACC_W-1:0]     o_zone3_s,
    output logic      [ACC_W-1:0]     o_zone4_s,
    output logic      [ACC_W-1:0]     o_zone5_s,
    output logic      [ACC_W-1:0]     o_zone6_s,
    output logic      [ACC_W-1:0]     o_zone7_s,
    output logic      [ACC_W-1:0]     o_total_s,
    output logic                      o_table_valid
);

    // configuration
    logic [FTP_W-1:0]  r_ftp;
    logic [STOP_W-1:0] r_stop;

    // input register
    logic               r_in_valid;
    logic               r_in_new_track;
    logic [TIME_W-1:0]  r_in_time;
    logic [POWER_W-1:0] r_in_power;

    // previous time stamp, all ones = none
    logic [TIME_W-1:0]  r_prev;
    logic [TIME_W-1:0]  n_prev;

    // result register
    logic               r_out_valid;
    logic [ZONE_W-1:0]  r_zone_hit;
    logic [ZONE_W-1:0]  n_zone_hit;

    logic               w_move;
    logic               w_time_ok;
    logic               w_prev_ok;
    logic [TIME_W-1:0]  w_diff;
    logic               w_step_ok;
    logic               w_count;
    logic [ZONE_W-1:0]  w_zone;
    t_acc_upd           w_upd;
    logic [ZONES-1:0][ACC_W-1:0] w_zone_s;

    // the input stage hands over when the result slot is free or being emptied
    assign w_move      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_move;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ftp  <= '0;
            r_stop <= STOP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FTP:  r_ftp  <= i_cfg_data;
                CFG_STOP: r_stop <= i_cfg_data[STOP_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_new_track <= i_new_track;
            r_in_time      <= i_time_s;
            r_in_power     <= i_power_w;
        end
    end

    // step qualification: both stamps valid, no new track, FTP nonzero, 1 <= step <= stop limit
    assign w_time_ok = !r_in_time[TIME_W-1];
    assign w_prev_ok = !r_prev[TIME_W-1] && !r_in_new_track;
    assign w_diff    = r_in_time - r_prev;
    assign w_step_ok = !w_diff[TIME_W-1] && (w_diff != '0)
                       && (w_diff[TIME_W-2:0] <= (TIME_W-1)'(r_stop));
    assign w_count   = w_time_ok && w_prev_ok && (r_ftp != '0) && w_step_ok;

    pzth_zone_sel u_zone_sel (
        .i_power_w   (r_in_power),
        .i_ftp_watts (r_ftp),
        .o_zone      (w_zone)
    );

    assign w_upd.clear = w_move && r_in_new_track;
    assign w_upd.add   = w_move && w_count;
    assign w_upd.zone  = w_zone;
    assign w_upd.step  = w_diff[STOP_W-1:0];

    pzth_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (w_upd),
        .o_zone_s  (w_zone_s),
        .o_total_s (o_total_s)
    );

    assign n_prev     = w_time_ok ? r_in_time : '1;
    assign n_zone_hit = w_count ? w_zone : NO_ZONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_move) begin
                r_prev <= n_prev;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_move) begin
            r_zone_hit <= n_zone_hit;
        end
    end

    // accumulators only change on a hand-over, so they track the held result
    assign o_out_valid   = r_out_valid;
    assign o_zone_hit    = r_zone_hit;
    assign o_zone1_s     = w_zone_s[0];
    assign o_zone2_s     = w_zone_s[1];
    assign o_zone3_s     = w_zone_s[2];
    assign o_zone4_s     = w_zone_s[3];
    assign o_zone5_s     = w_zone_s[4];
    assign o_zone6_s     = w_zone_s[5];
    assign o_zone7_s     = w_zone_s[6];
    assign o_table_valid = (o_total_s != '0);

    // a credited zone means some time has been counted
    a_hit_implies_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_zone_hit != NO_ZONE) |-> o_table_valid)
        else $error("zone credited with zero total");

    // FTP of zero never credits a zone
    a_ftp_zero_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_ftp == '0) |=> (r_zone_hit == NO_ZONE))
        else $error("zone credited with FTP zero");

    // accumulators hold while no hand-over happens
    a_total_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_move) |=> $stable(o_total_s))
        else $error("total changed without a hand-over");

    // new track leaves the first sample uncounted
    a_new_track_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_in_new_track) |=> (o_total_s == '0 && r_zone_hit == NO_ZONE))
        else $error("new track did not clear state");

endmodule : power_zone_time_histogram
`default_nettype wire

### design/pzth_zone_sel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pzth_zone_sel
// Six parallel edge comparators picking the power zone for one sample.
// ----------------------------------------------------------------------------
module pzth_zone_sel import pzth_pkg::*; (
    input  wire logic [POWER_W-1:0] i_power_w,
    input  wire logic [FTP_W-1:0]   i_ftp_watts,
    output logic      [ZONE_W-1:0]  o_zone
);

    logic [16:0] w_p20;
    logic [15:0] w_edge [EDGES];

    assign w_p20 = 17'(i_power_w) * 17'(POWER_SCALE);

    always_comb begin
        o_zone = '0;
        for (int k = 0; k < EDGES; k++) begin
            w_edge[k] = 16'(16'(i_ftp_watts) * 16'(EDGE_K[k]));
            // edges rise with k, so the last one met wins
            if (w_p20 >= 17'(w_edge[k])) begin
                o_zone = ZONE_W'(k + 1);
            end
        end
    end

endmodule : pzth_zone_sel
`default_nettype wire

### design/pzth_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pzth_accum
// Seven saturating zone accumulators and a saturating total.
// ----------------------------------------------------------------------------
module pzth_accum import pzth_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_acc_upd                    i_upd,
    output logic      [ZONES-1:0][ACC_W-1:0] o_zone_s,
    output logic      [ACC_W-1:0]            o_total_s
);

    logic [ACC_W-1:0] r_zone [ZONES];
    logic [ACC_W-1:0] n_zone [ZONES];
    logic [ACC_W-1:0] r_total;
    logic [ACC_W-1:0] n_total;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [STOP_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + (ACC_W+1)'(b);
        return s[ACC_W] ? '1 : s[ACC_W-1:0];
    endfunction

    always_comb begin
        n_total = r_total;
        for (int k = 0; k < ZONES; k++) begin
            n_zone[k] = r_zone[k];
            if (i_upd.clear) begin
                n_zone[k] = '0;
            end else if (i_upd.add && i_upd.zone == ZONE_W'(k)) begin
                n_zone[k] = sat_add(r_zone[k], i_upd.step);
            end
        end
        if (i_upd.clear) begin
            n_total = '0;
        end else if (i_upd.add) begin
            n_total = sat_add(r_total, i_upd.step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int k = 0; k < ZONES; k++) begin
                r_zone[k] <= '0;
            end
        end else begin
            r_total <= n_total;
            for (int k = 0; k < ZONES; k++) begin
                r_zone[k] <= n_zone[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < ZONES; k++) begin
            o_zone_s[k] = r_zone[k];
        end
    end

    assign o_total_s = r_total;

endmodule : pzth_accum
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the power time-in-zone histogram. A directed table
// covers the zone edges, the stop limit, missing stamps, new tracks and the
// extremes of every field. A long random run follows, made mostly of
// well-formed rides with random steps and powers near the zone edges. Every
// result word is checked field by field against a behavioural predictor kept
// in the bench, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb import pzth_pkg::*;;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 10;
    localparam int TIME_MAX        = (1 << (TIME_W - 1)) - 1;
    localparam int WATT_MAX        = (1 << POWER_W) - 1;
    localparam int WATT_SCALE      = 20;
    localparam int RIDE_PHASES     = 8;
    localparam int WORDS_PER_PHASE = 200;
    // one long hold on the result side once this many results are in
    localparam int SQUEEZE_AT      = 450;
    localparam int SQUEEZE_LEN     = 150;
    // worst quiet stretch of a correct run is the squeeze plus a long gap
    localparam int WATCHDOG_LIMIT  = 2000;
    // settling wait after the last result; two pipeline stages may still hold a stray word
    localparam int SETTLE_CYCLES   = 8;

    // lower zone edges in twentieths of FTP: 0.55 .. 1.50
    localparam int ZONE_EDGE [EDGES] = '{11, 15, 18, 21, 24, 30};

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        logic [ZONE_W-1:0]           hit;
        logic [ZONES-1:0][ACC_W-1:0] secs;
        logic [ACC_W-1:0]            total;
        logic                        tv;
    } t_zone_result;

    typedef struct packed {
        t_row_kind            kind;
        logic                 fresh;
        logic [TIME_W-1:0]    stamp;
        logic [POWER_W-1:0]   watts;
        logic [ZONE_W-1:0]    hit;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [FTP_W-1:0]     reg_val;
    } t_plan_row;

    // DUT inputs: known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FTP_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_new_track = 1'b0;
    logic [TIME_W-1:0]    i_time_s    = '0;
    logic [POWER_W-1:0]   i_power_w   = '0;
    logic                 i_out_ready = 1'b0;

    logic                 o_cfg_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [ZONE_W-1:0]    o_zone_hit;
    logic [ACC_W-1:0]     o_zone1_s, o_zone2_s, o_zone3_s, o_zone4_s;
    logic [ACC_W-1:0]     o_zone5_s, o_zone6_s, o_zone7_s, o_total_s;
    logic                 o_table_valid;

    // predictor copy of the registers and the ride state
    logic [FTP_W-1:0]     ftp_now;
    logic [STOP_W-1:0]    stop_now;
    int                   last_stamp;
    logic [ACC_W-1:0]     zone_acc [ZONES];
    logic [ACC_W-1:0]     total_acc;

    t_zone_result         results_due [$];
    t_plan_row            plan [$];
    int                   mismatches   = 0;
    int                   results_seen = 0;
    int                   quiet_cycles = 0;
    int                   hold_left    = 0;
    bit                   squeezed     = 1'b0;
    // no idling at all on either side while set
    bit                   steady       = 1'b0;

    power_zone_time_histogram i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_new_track   (i_new_track),
        .i_time_s      (i_time_s),
        .i_power_w     (i_power_w),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_zone_hit    (o_zone_hit),
        .o_zone1_s     (o_zone1_s),
        .o_zone2_s     (o_zone2_s),
        .o_zone3_s     (o_zone3_s),
        .o_zone4_s     (o_zone4_s),
        .o_zone5_s     (o_zone5_s),
        .o_zone6_s     (o_zone6_s),
        .o_zone7_s     (o_zone7_s),
        .o_total_s     (o_total_s),
        .o_table_valid (o_table_valid)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [ACC_W-1:0] add_sat(logic [ACC_W-1:0] a, int unsigned b);
        logic [ACC_W:0] s;
        s = a + b;
        return s[ACC_W] ? '1 : s[ACC_W-1:0];
    endfunction

    function automatic void clear_ride();
        last_stamp = -1;
        for (int k = 0; k < ZONES; k++)
            zone_acc[k] = '0;
        total_acc = '0;
    endfunction

    // one sample through the histogram; returns the word it should produce
    function automatic t_zone_result ride_step(logic fresh, int stamp,
                                               logic [POWER_W-1:0] watts);
        t_zone_result r;
        int gap_s, p20, z;
        if (fresh)
            clear_ride();
        r.hit = NO_ZONE;
        // both stamps present and a threshold set, else nothing is credited
        if (stamp >= 0 && last_stamp >= 0 && ftp_now != '0) begin
            gap_s = stamp - last_stamp;
            // zero, backwards or longer than the stop limit: a pause, not riding
            if (gap_s >= 1 && gap_s <= int'(stop_now)) begin
                p20 = int'(watts) * WATT_SCALE;
                z = 0;
                for (int k = 0; k < EDGES; k++)
                    if (p20 >= int'(ftp_now) * ZONE_EDGE[k])
                        z = k + 1;
                zone_acc[z] = add_sat(zone_acc[z], gap_s);
                total_acc   = add_sat(total_acc, gap_s);
                r.hit = ZONE_W'(z);
            end
        end
        // the previous stamp always follows the sample, a missing one too
        last_stamp = (stamp < 0) ? -1 : stamp;
        for (int k = 0; k < ZONES; k++)
            r.secs[k] = zone_acc[k];
        r.total = total_acc;
        r.tv    = (total_acc != '0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int track_start();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(TIME_MAX - 4000, TIME_MAX);
        return $urandom_range(0, TIME_MAX / 2);
    endfunction

    // powers cluster round the zone edges of the current FTP
    function automatic logic [POWER_W-1:0] pick_watts();
        int r, w, e;
        r = $urandom_range(0, 99);
        if (r < 10)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        if (ftp_now != '0 && r < 60) begin
            e = $urandom_range(0, EDGES - 1);
            w = (int'(ftp_now) * ZONE_EDGE[e] + WATT_SCALE - 1) / WATT_SCALE
                + int'($urandom_range(0, 4)) - 2;
        end else if (ftp_now != '0 && r < 85) begin
            w = $urandom_range(0, 2 * ftp_now);
        end else begin
            w = $urandom_range(0, WATT_MAX);
        end
        if (w < 0)
            w = 0;
        if (w > WATT_MAX)
            w = WATT_MAX;
        return POWER_W'(w);
    endfunction

    function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, int val);
        t_plan_row row;
        row = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = FTP_W'(val);
        plan.insert(plan.size(), row);
    endfunction

    function automatic void plan_sample(logic fresh, int stamp, int watts,
                                        logic [ZONE_W-1:0] hit);
        t_plan_row row;
        row = '0;
        row.kind  = ROW_SAMPLE;
        row.fresh = fresh;
        row.stamp = TIME_W'(stamp);
        row.watts = POWER_W'(watts);
        row.hit   = hit;
        plan.insert(plan.size(), row);
    endfunction

    // offer one sample word; valid stays up afterwards so the next word can
    // follow back to back. pin_hit >= 0 overrides the predicted zone.
    task automatic send_sample(logic fresh, int stamp, logic [POWER_W-1:0] watts,
                               int pin_hit);
        t_zone_result want;
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_new_track <= fresh;
        i_time_s    <= TIME_W'(stamp);
        i_power_w   <= watts;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        want = ride_step(fresh, stamp, watts);
        if (pin_hit >= 0)
            want.hit = ZONE_W'(pin_hit);
        results_due.insert(results_due.size(), want);
    endtask

    // register writes only once every result word has been collected
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FTP_W-1:0] val);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FTP)
            ftp_now = val;
        else if (idx == CFG_STOP)
            stop_now = val[STOP_W-1:0];
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int phase_ftp, phase_stop, lim, ride_clock, stamp, step, r;
        logic fresh;

        ftp_now  = '0;
        stop_now = STOP_RST;
        clear_ride();

        // directed table, FTP 200 puts the edges at 110/150/180/210/240/300 W
        plan_sample(1'b0, 0, 100, NO_ZONE);            // no previous stamp
        plan_sample(1'b0, 1, 100, NO_ZONE);            // FTP still zero
        plan_write(CFG_FTP, 200);
        plan_write(CFG_STOP, 20);
        plan_sample(1'b0, 2, 0, 3'd0);
        plan_sample(1'b0, 4, 109, 3'd0);               // just under each edge ...
        plan_sample(1'b0, 5, 110, 3'd1);               // ... and exactly on it
        plan_sample(1'b0, 6, 149, 3'd1);
        plan_sample(1'b0, 7, 150, 3'd2);
        plan_sample(1'b0, 8, 179, 3'd2);
        plan_sample(1'b0, 9, 180, 3'd3);
        plan_sample(1'b0, 11, 210, 3'd4);
        plan_sample(1'b0, 12, 240, 3'd5);
        plan_sample(1'b0, 13, 300, 3'd6);
        plan_sample(1'b0, 33, WATT_MAX, 3'd6);         // step equal to the limit
        plan_sample(1'b0, 54, 100, NO_ZONE);           // one past the limit
        plan_sample(1'b0, 54, 100, NO_ZONE);           // zero step
        plan_sample(1'b0, 50, 100, NO_ZONE);           // going backwards
        plan_sample(1'b0, -1, 100, NO_ZONE);           // missing stamp
        plan_sample(1'b0, 51, 100, NO_ZONE);           // previous was missing
        plan_sample(1'b1, 52, 100, NO_ZONE);           // new track wipes the lot
        plan_sample(1'b0, 53, 150, 3'd2);
        plan_sample(1'b0, TIME_MAX - 19, 100, NO_ZONE);
        plan_sample(1'b0, TIME_MAX, WATT_MAX, 3'd6);   // top of the time range
        plan_write(CFG_STOP, 0);                       // nothing can count
        plan_sample(1'b1, 0, 100, NO_ZONE);
        plan_sample(1'b0, 1, 100, NO_ZONE);
        plan_write(CFG_FTP, (1 << FTP_W) - 1);
        plan_write(CFG_STOP, (1 << STOP_W) - 1);
        plan_sample(1'b1, 100, 0, NO_ZONE);
        plan_sample(1'b0, 355, WATT_MAX, 3'd6);        // longest step allowed
        plan_sample(1'b0, 356, 562, 3'd0);
        plan_write(CFG_FTP, 1);
        plan_write(CFG_STOP, 1);
        plan_sample(1'b0, 357, 0, 3'd0);
        plan_sample(1'b0, 358, 1, 3'd3);               // 20 W-units is 1.00 of FTP, zone code 3
        plan_sample(1'b0, 360, 1, NO_ZONE);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_WRITE)
                write_reg(plan[n].reg_idx, plan[n].reg_val);
            else
                send_sample(plan[n].fresh, int'($signed(plan[n].stamp)),
                            plan[n].watts, int'(plan[n].hit));
        end

        // random rides, one register setting per phase
        for (int phase = 0; phase < RIDE_PHASES; phase++) begin
            case (phase)
                0: begin
                    phase_ftp  = 250;
                    phase_stop = 20;
                end
                1: begin
                    phase_ftp  = (1 << FTP_W) - 1;
                    phase_stop = (1 << STOP_W) - 1;
                end
                2: begin
                    phase_ftp  = 1;
                    phase_stop = 1;
                end
                3: begin
                    phase_ftp  = 0;
                    phase_stop = $urandom_range(1, 255);
                end
                default: begin
                    phase_ftp  = $urandom_range(1, (1 << FTP_W) - 1);
                    phase_stop = $urandom_range(1, 255);
                end
            endcase
            write_reg(CFG_FTP, FTP_W'(phase_ftp));
            write_reg(CFG_STOP, FTP_W'(phase_stop));
            lim = (phase_stop == 0) ? 1 : phase_stop;
            ride_clock = -1;

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n % 64 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                fresh = 1'b0;
                if (r < 3) begin
                    fresh = 1'b1;
                    stamp = track_start();
                end else if (r < 78) begin
                    // ordinary riding step, now and then right on the limit
                    step  = ($urandom_range(0, 4) == 0) ? lim : $urandom_range(1, lim);
                    stamp = (ride_clock < 0) ? track_start() : ride_clock + step;
                end else if (r < 83) begin
                    stamp = (ride_clock < 0) ? track_start() : ride_clock;
                end else if (r < 88) begin
                    stamp = ride_clock + lim + $urandom_range(1, 100);
                end else if (r < 91) begin
                    stamp = (ride_clock > 50) ? ride_clock - int'($urandom_range(1, 50)) : 0;
                end else if (r < 95) begin
                    stamp = -1;
                end else begin
                    fresh = ($urandom_range(0, 1) != 0);
                    stamp = $urandom_range(0, TIME_MAX);
                end
                if (stamp > TIME_MAX) begin
                    fresh = 1'b1;
                    stamp = track_start();
                end
                send_sample(fresh, stamp, pick_watts(), -1);
                ride_clock = stamp;
            end
        end

        i_in_valid <= 1'b0;
        steady = 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: ready pattern and checking
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [ACC_W-1:0] want, logic [ACC_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_side
        t_zone_result want, got;
        logic took;

        took = i_rst_n && o_out_valid && i_out_ready;
        if (took) begin
            results_seen++;
            got.hit     = o_zone_hit;
            got.secs[0] = o_zone1_s;
            got.secs[1] = o_zone2_s;
            got.secs[2] = o_zone3_s;
            got.secs[3] = o_zone4_s;
            got.secs[4] = o_zone5_s;
            got.secs[5] = o_zone6_s;
            got.secs[6] = o_zone7_s;
            got.total   = o_total_s;
            got.tv      = o_table_valid;
            if (results_due.size() == 0) begin
                $display("%0t: result word expected none got zone_hit %0d total_s %0d",
                         $time, got.hit, got.total);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("zone_hit", want.hit, got.hit);
                for (int k = 0; k < ZONES; k++)
                    check_field($sformatf("zone%0d_s", k + 1), want.secs[k], got.secs[k]);
                check_field("total_s", want.total, got.total);
                check_field("table_valid", want.tv, got.tv);
            end
        end

        // one assignment to ready per edge: hold, start the long squeeze,
        // start a random stall after a word, or stay ready
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (took && !squeezed && results_seen >= SQUEEZE_AT) begin
            // input keeps offering words, so both stages fill and in_ready drops
            squeezed  = 1'b1;
            hold_left = SQUEEZE_LEN - 1;
            i_out_ready <= 1'b0;
        end else if (took && idle_gap() > 0) begin
            hold_left = idle_gap();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any accepted word on any channel restarts the count
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, results_due.size());
            $display("tb NOT OK");
            $finish;
        end
    end

endmodule

### sim.f
design/pzth_pkg.sv
design/pzth_zone_sel.sv
design/pzth_accum.sv
design/power_zone_time_histogram.sv
bench/tb.sv
